// ===== design/hef_pkg.sv =====
// ----------------------------------------------------------------------------
// hef_pkg
// Types and fixed constants shared by the envelope follower modules.
// ----------------------------------------------------------------------------
package hef_pkg;

   localparam int SAMPLE_W = 16;
   localparam int DECAY_W  = 15;
   localparam int ENV_W    = 24;
   localparam int HIL_W    = 17;
   localparam int WMAG_W   = 23;
   localparam int WT_W     = WMAG_W + 1;
   localparam int MULA_W   = 17;
   localparam int MULB_W   = 25;
   localparam int PROD_W   = MULA_W + MULB_W;
   localparam int ACC_W    = 52;
   localparam int QNT_W    = ACC_W + 1 - 24;
   localparam int E_W      = 18;

   localparam longint unsigned INV_PI_Q24 = 64'd5340354;
   localparam logic [DECAY_W-1:0] DECAY_RESET = 15'd32604;
   localparam logic [ENV_W-1:0]   ENV_MAX     = 24'hFFFFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN_A,
      ST_DRAIN_B,
      ST_HILB,
      ST_ENV_MUL,
      ST_ENV_ADD
   } hef_state_type;

   typedef struct packed {
      logic                   start;
      logic                   clear_level;
      logic                   rd_en;
      logic                   tap_mid;
      logic signed [WT_W-1:0] weight;
      logic                   hilb;
      logic                   env_mul;
      logic                   load_out;
   } hef_ctrl_type;

endpackage

// ===== design/hef_intf.sv =====
// ----------------------------------------------------------------------------
// hef_intf
// Valid/ready channels for sample, result and decay register beats.
// ----------------------------------------------------------------------------
interface hef_req_intf
   import hef_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       clip_start;

   modport source (output valid, sample, clip_start, input ready);
   modport sink (input valid, sample, clip_start, output ready);
endinterface

interface hef_rsp_intf
   import hef_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [ENV_W-1:0]        envelope;
   logic signed [HIL_W-1:0] hilbert_value;
   logic                    saturated;

   modport source (output valid, envelope, hilbert_value, saturated, input ready);
   modport sink (input valid, envelope, hilbert_value, saturated, output ready);
endinterface

interface hef_csr_intf
   import hef_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [DECAY_W-1:0] decay;

   modport source (output valid, decay, input ready);
   modport sink (input valid, decay, output ready);
endinterface

// ===== design/hef_ram.sv =====
// ----------------------------------------------------------------------------
// hef_ram
// Sample delay memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hef_ram
   import hef_pkg::*;
#(
   parameter int DEPTH = 129,
   parameter int AW    = 8
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic signed [SAMPLE_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic signed [SAMPLE_W-1:0] rd_data_ff
);

   logic signed [SAMPLE_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== design/hef_seq.sv =====
// ----------------------------------------------------------------------------
// hef_seq
// Sequencer: sample counting, delay addressing, kernel weights, step control.
// ----------------------------------------------------------------------------
module hef_seq
   import hef_pkg::*;
#(
   parameter int TAPS = 128
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_clip_start,
   output logic                             req_ready,
   output logic                             wr_en,
   output logic [$clog2(TAPS+1)-1:0]        wr_addr,
   output logic [$clog2(TAPS+1)-1:0]        rd_addr,
   input  logic                             out_free,
   output hef_ctrl_type                     ctrl
);

   localparam int HALF = TAPS / 2;
   localparam int KW   = $clog2(TAPS + 1);
   localparam int SW   = $clog2(TAPS + 2);
   localparam int HW   = $clog2(HALF + 1);

   hef_state_type state_ff, state_in;

   logic [SW-1:0] seen_ff, seen_in;
   logic [KW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [KW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [KW-1:0] k_ff, k_in;
   logic [KW-1:0] k_last_ff, k_last_in;

   logic                   accept;
   logic [SW-1:0]          t_cur;
   logic                   t_full;
   logic                   t_emit;
   logic [KW-1:0]          head_ptr;
   logic [HW-1:0]          wt_idx;
   logic [WMAG_W-1:0]      wt_mag [HALF+1];
   logic signed [WT_W-1:0] wt_pos;

   for (genvar g = 0; g <= HALF; g++) begin : g_wt
      localparam longint unsigned NUM = (g == 0) ? 64'd0 :
                                        (g == HALF) ? INV_PI_Q24 :
                                        INV_PI_Q24 * 64'd4 * longint'(g);
      localparam longint unsigned DEN = (g == 0) ? 64'd1 :
                                        (g == HALF) ? longint'(TAPS - 1) :
                                        64'd4 * longint'(g) * longint'(g) - 64'd1;
      localparam longint unsigned MAG = (NUM + DEN / 64'd2) / DEN;
      assign wt_mag[g] = WMAG_W'(MAG);
   end

   assign accept   = (state_ff == ST_IDLE) && req_valid;
   assign t_cur    = req_clip_start ? '0 : seen_ff;
   assign t_full   = t_cur > SW'(TAPS);
   assign t_emit   = t_cur >= SW'(HALF);
   assign head_ptr = (wr_ptr_ff >= KW'(HALF)) ? wr_ptr_ff - KW'(HALF)
                                              : wr_ptr_ff + KW'(TAPS + 1 - HALF);
   assign wt_idx   = (k_ff < KW'(HALF)) ? HW'(KW'(HALF) - k_ff) : HW'(k_ff - KW'(HALF));
   assign wt_pos   = $signed({1'b0, wt_mag[wt_idx]});

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && t_emit) begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (k_ff == k_last_ff) begin
               state_in = ST_DRAIN_A;
            end
         end
         ST_DRAIN_A: state_in = ST_DRAIN_B;
         ST_DRAIN_B: state_in = ST_HILB;
         ST_HILB:    state_in = ST_ENV_MUL;
         ST_ENV_MUL: state_in = ST_ENV_ADD;
         ST_ENV_ADD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready        = (state_ff == ST_IDLE);
      wr_en            = accept;
      wr_addr          = wr_ptr_ff;
      rd_addr          = rd_ptr_ff;
      ctrl.start       = accept;
      ctrl.clear_level = accept && req_clip_start;
      ctrl.rd_en       = (state_ff == ST_MAC);
      ctrl.tap_mid     = (k_ff == KW'(HALF));
      ctrl.weight      = (k_ff < KW'(HALF)) ? -wt_pos : wt_pos;
      ctrl.hilb        = (state_ff == ST_HILB);
      ctrl.env_mul     = (state_ff == ST_ENV_MUL);
      ctrl.load_out    = (state_ff == ST_ENV_ADD) && out_free;
   end

   always_comb begin
      seen_in   = seen_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      k_in      = k_ff;
      k_last_in = k_last_ff;
      if (accept) begin
         seen_in   = (t_cur < SW'(TAPS + 1)) ? t_cur + SW'(1) : t_cur;
         wr_ptr_in = (wr_ptr_ff == KW'(TAPS)) ? '0 : wr_ptr_ff + KW'(1);
         k_in      = t_full ? '0 : KW'(HALF);
         k_last_in = t_full ? KW'(TAPS) : KW'(HALF);
         rd_ptr_in = t_full ? wr_ptr_ff : head_ptr;
      end else if (state_ff == ST_MAC) begin
         k_in      = k_ff + KW'(1);
         rd_ptr_in = (rd_ptr_ff == '0) ? KW'(TAPS) : rd_ptr_ff - KW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         seen_ff   <= '0;
         wr_ptr_ff <= '0;
      end else begin
         state_ff  <= state_in;
         seen_ff   <= seen_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
      k_ff      <= k_in;
      k_last_ff <= k_last_in;
   end

endmodule

// ===== design/hef_dp.sv =====
// ----------------------------------------------------------------------------
// hef_dp
// Datapath: shared multiplier, accumulator, Hilbert rounding, leaky envelope.
// ----------------------------------------------------------------------------
module hef_dp
   import hef_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  hef_ctrl_type               ctrl,
   input  logic signed [SAMPLE_W-1:0] rd_data,
   input  logic [DECAY_W-1:0]         decay,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic [ENV_W-1:0]           rsp_envelope,
   output logic signed [HIL_W-1:0]    rsp_hilbert_value,
   output logic                       rsp_saturated,
   output logic                       out_free
);

   logic                       tap_valid_ff;
   logic                       tap_mid_ff;
   logic signed [WT_W-1:0]     weight_ff;
   logic                       prod_valid_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [SAMPLE_W-1:0] xd_ff;
   logic signed [HIL_W-1:0]    h_ff;
   logic [E_W-1:0]             e_ff;
   logic [ENV_W-1:0]           level_ff;
   logic                       rsp_valid_ff;
   logic [ENV_W-1:0]           env_ff;
   logic signed [HIL_W-1:0]    hout_ff;
   logic                       sat_ff;

   logic signed [MULA_W-1:0]   mul_a;
   logic signed [MULB_W-1:0]   mul_b;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [ACC_W:0]      acc_rnd;
   logic signed [QNT_W-1:0]    q_val;
   logic signed [HIL_W-1:0]    h_in;
   logic signed [HIL_W:0]      h_ext;
   logic signed [HIL_W-1:0]    xd_ext;
   logic [E_W-1:0]             h_abs;
   logic [HIL_W-1:0]           xd_abs;
   logic [39:0]                scaled;
   logic [ENV_W+1:0]           env_sum;
   logic                       env_over;

   assign mul_a   = ctrl.env_mul ? $signed({2'b00, decay}) : MULA_W'(rd_data);
   assign mul_b   = ctrl.env_mul ? $signed({1'b0, level_ff}) : MULB_W'(weight_ff);
   assign prod_in = mul_a * mul_b;

   assign acc_rnd = (ACC_W + 1)'(acc_ff) + (ACC_W + 1)'(64'sd8388608);
   assign q_val   = acc_rnd[ACC_W:24];
   always_comb begin
      priority if (q_val > QNT_W'(65535)) begin
         h_in = HIL_W'(65535);
      end else if (q_val < -QNT_W'(65536)) begin
         h_in = HIL_W'(-65536);
      end else begin
         h_in = HIL_W'(q_val);
      end
   end

   assign h_ext    = (HIL_W + 1)'(h_ff);
   assign h_abs    = h_ext[HIL_W] ? E_W'(-h_ext) : E_W'(h_ext);
   assign xd_ext   = HIL_W'(xd_ff);
   assign xd_abs   = xd_ext[HIL_W-1] ? HIL_W'(-xd_ext) : HIL_W'(xd_ext);
   assign scaled   = 40'(prod_ff[38:0]) + 40'd16384;
   assign env_sum  = (ENV_W + 2)'(e_ff) + (ENV_W + 2)'(scaled[39:15]);
   assign env_over = env_sum > (ENV_W + 2)'(ENV_MAX);

   assign out_free          = !rsp_valid_ff || rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_envelope      = env_ff;
   assign rsp_hilbert_value = hout_ff;
   assign rsp_saturated     = sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
         level_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         tap_valid_ff  <= ctrl.rd_en;
         prod_valid_ff <= tap_valid_ff;
         if (ctrl.clear_level) begin
            level_ff <= '0;
         end else if (ctrl.load_out) begin
            level_ff <= env_over ? ENV_MAX : env_sum[ENV_W-1:0];
         end
         if (ctrl.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      tap_mid_ff <= ctrl.tap_mid;
      weight_ff  <= ctrl.weight;
      if (tap_valid_ff || ctrl.env_mul) begin
         prod_ff <= prod_in;
      end
      if (tap_valid_ff && tap_mid_ff) begin
         xd_ff <= rd_data;
      end
      if (ctrl.start) begin
         acc_ff <= '0;
      end else if (prod_valid_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (ctrl.hilb) begin
         h_ff <= h_in;
      end
      if (ctrl.env_mul) begin
         e_ff <= E_W'(xd_abs) + h_abs;
      end
      if (ctrl.load_out) begin
         env_ff  <= env_over ? ENV_MAX : env_sum[ENV_W-1:0];
         sat_ff  <= env_over;
         hout_ff <= h_ff;
      end
   end

endmodule

// ===== design/hilbert_envelope_follower.sv =====
// ----------------------------------------------------------------------------
// hilbert_envelope_follower
// Hilbert-transform envelope follower with a leaky, saturating smoother.
//
// Samples arrive as beats on req_ch (sample, clip_start); results leave as
// beats on rsp_ch (envelope, hilbert_value, saturated). csr_ch writes the
// decay factor; it is always ready. The user must see that it is written
// only while idle; the block does not enforce this. A beat with clip_start
// set clears the smoothed level and the sample count before the sample is
// taken in. The first TAPS/2 samples of a clip give no result; they are
// only written to the delay memory. The next TAPS/2+1 give a result with
// hilbert_value zero. Later samples run the full kernel through one shared
// multiplier, one tap per cycle, with the result valid on the cycle after the
// sequence ends.
// req_ch.ready is high only in the idle state. A finished result waits in
// the output register, so the next sample is taken while rsp_ch stalls; a
// second result waits in the last step until the register frees.
// Reset sets decay to its default and starts a clip; the delay memory is
// not cleared, as the sample count keeps stale entries out of every sum.
// ----------------------------------------------------------------------------
module hilbert_envelope_follower
   import hef_pkg::*;
#(
   parameter int TAPS = 128
) (
   input  logic         clock,
   input  logic         reset,
   hef_req_intf.sink    req_ch,
   hef_rsp_intf.source  rsp_ch,
   hef_csr_intf.sink    csr_ch
);

   localparam int AW = $clog2(TAPS + 1);

   logic [DECAY_W-1:0]         decay_ff;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [AW-1:0]              rd_addr;
   logic signed [SAMPLE_W-1:0] rd_data;
   logic                       out_free;
   hef_ctrl_type               ctrl;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff <= DECAY_RESET;
      end else if (csr_ch.valid) begin
         decay_ff <= csr_ch.decay;
      end
   end

   hef_seq #(
      .TAPS (TAPS)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_clip_start (req_ch.clip_start),
      .req_ready      (req_ch.ready),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .rd_addr        (rd_addr),
      .out_free       (out_free),
      .ctrl           (ctrl)
   );

   hef_ram #(
      .DEPTH (TAPS + 1),
      .AW    (AW)
   ) u_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (req_ch.sample),
      .rd_en      (ctrl.rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   hef_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .rd_data           (rd_data),
      .decay             (decay_ff),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_envelope      (rsp_ch.envelope),
      .rsp_hilbert_value (rsp_ch.hilbert_value),
      .rsp_saturated     (rsp_ch.saturated),
      .out_free          (out_free)
   );

endmodule

// ===== tb/hilbert_envelope_follower_test.sv =====
// ----------------------------------------------------------------------------
// hilbert_envelope_follower_test
// Self-checking bench for the Hilbert envelope follower. A scoreboard keeps
// its own delay line, kernel and leaky sum, predicts every result beat from
// the accepted sample beats and compares field by field. Stimulus runs
// directed extremes, then clips of shaped waveforms and noise under several
// decay settings, with random sender bursts, receiver stalls and one long
// receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module hilbert_envelope_follower_test
   import hef_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TAPS       = 128;
   localparam int HALF       = TAPS / 2;
   localparam int LIMIT      = 3000000;
   localparam int SETTLE     = 200;
   localparam int HOLD_CYC   = 3000;
   localparam int HOLD_AFTER = 500;

   typedef enum int {
      WAVE_NOISE,
      WAVE_SQUARE,
      WAVE_TRIANGLE,
      WAVE_SPARSE,
      WAVE_SMALL
   } wave_kind_type;

   typedef struct {
      logic [ENV_W-1:0]        envelope;
      logic signed [HIL_W-1:0] hilbert_value;
      logic                    saturated;
   } envelope_beat_type;

   class envelope_scoreboard;
      longint             tap_weight[TAPS+1];
      int                 history[TAPS+1];
      longint             level;
      int                 seen;
      logic [DECAY_W-1:0] decay;
      envelope_beat_type  pending[$];
      int                 mismatches;

      function new();
         longint p, a, mag, den;
         int d;
         p = longint'(INV_PI_Q24);
         for (int k = 0; k <= TAPS; k++) begin
            d = HALF - k;
            a = (d < 0) ? -d : d;
            if (a == 0) begin
               mag = 0;
            end else if (a >= HALF) begin
               den = TAPS - 1;
               mag = (p + den / 2) / den;
            end else begin
               den = 4 * a * a - 1;
               mag = (p * 4 * a + den / 2) / den;
            end
            tap_weight[k] = (d < 0) ? mag : -mag;
         end
         decay = DECAY_RESET;
         mismatches = 0;
         clear_clip();
      endfunction

      function void clear_clip();
         foreach (history[k]) history[k] = 0;
         level = 0;
         seen = 0;
      endfunction

      function void set_decay(logic [DECAY_W-1:0] d);
         decay = d;
      endfunction

      function int outstanding();
         return pending.size();
      endfunction

      function void note_sample(logic signed [SAMPLE_W-1:0] x, logic clip);
         envelope_beat_type beat;
         int stage, xd, hval;
         longint acc, q, e, s;
         if (clip)
            clear_clip();
         for (int k = TAPS; k > 0; k--)
            history[k] = history[k-1];
         history[0] = int'(x);
         stage = seen;
         if (seen < TAPS + 1)
            seen++;
         if (stage < HALF)
            return;
         hval = 0;
         if (stage > TAPS) begin
            acc = 0;
            for (int k = 0; k <= TAPS; k++)
               acc += longint'(history[k]) * tap_weight[k];
            q = (acc + 64'sd8388608) >>> 24;
            if (q > 65535)
               q = 65535;
            if (q < -65536)
               q = -65536;
            hval = int'(q);
         end
         xd = history[HALF];
         e = ((xd < 0) ? -xd : xd) + ((hval < 0) ? -hval : hval);
         s = e + ((longint'(decay) * level + 16384) >>> 15);
         beat.saturated = 1'b0;
         if (s > longint'(ENV_MAX)) begin
            s = longint'(ENV_MAX);
            beat.saturated = 1'b1;
         end
         level = s;
         beat.envelope = s[ENV_W-1:0];
         beat.hilbert_value = hval[HIL_W-1:0];
         pending.push_back(beat);
      endfunction

      function void check_result(logic [ENV_W-1:0] env, logic signed [HIL_W-1:0] hil,
                                 logic sat);
         envelope_beat_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: envelope %0d hilbert %0d saturated %0b",
                        env, hil, sat);
            return;
         end
         want = pending.pop_front();
         if (want.envelope !== env || want.hilbert_value !== hil
             || want.saturated !== sat) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result mismatch: expected env %0d hil %0d sat %0b, got %0d %0d %0b",
                        want.envelope, want.hilbert_value, want.saturated, env, hil, sat);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   hef_req_intf req_ch ();
   hef_rsp_intf rsp_ch ();
   hef_csr_intf csr_ch ();

   hilbert_envelope_follower #(
      .TAPS(TAPS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   envelope_scoreboard sb;
   int  cycles = 0;
   int  sent_count = 0;
   int  burst_left = 0;
   bit  hold_rsp = 1'b0;

   logic signed [SAMPLE_W-1:0] directed_samples[24] = '{
      16'sh7FFF, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh0001, 16'sh4000, -16'sh4000,
      16'sh7FFF, -16'sh8000, 16'sh7FFF, 16'sh5555, -16'sh5556, 16'sh0000, -16'sh0001,
      16'sh7FFF, -16'sh8000, 16'sh0000, 16'sh7FFF, -16'sh8000, 16'sh0001, 16'sh7FFE,
      -16'sh7FFF, 16'sh0000, 16'sh7FFF
   };
   bit directed_clip[24] = '{
      0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0, 1, 0, 0, 0
   };

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_sample(logic signed [SAMPLE_W-1:0] x, logic clip);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: gap = 0;
            9:             gap = $urandom_range(20, 300);
            default:       gap = $urandom_range(1, 20);
         endcase
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid      <= 1'b1;
      req_ch.sample     <= x;
      req_ch.clip_start <= clip;
      do
         @(posedge clock);
      while (!req_ch.ready);
      sb.note_sample(x, clip);
      sent_count++;
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (sb.outstanding() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_decay(logic [DECAY_W-1:0] d);
      csr_ch.valid <= 1'b1;
      csr_ch.decay <= d;
      do
         @(posedge clock);
      while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      sb.set_decay(d);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] wave_value(wave_kind_type kind, int n,
                                                              int period, int amp);
      int ph;
      ph = n % period;
      case (kind)
         WAVE_SQUARE:   return SAMPLE_W'((ph < period / 2) ? amp : -amp - 1);
         WAVE_TRIANGLE: return SAMPLE_W'(-amp + (2 * amp * ph) / period);
         WAVE_SPARSE:   return SAMPLE_W'(($urandom_range(0, 7) != 0) ? 0 : $urandom());
         WAVE_SMALL:    return SAMPLE_W'($urandom_range(0, 15) - 8);
         default:       return SAMPLE_W'($urandom());
      endcase
   endfunction

   task automatic run_phase(int count, bit loud);
      int done, len, period, amp;
      bit first, broken, lead_flag, clip;
      wave_kind_type kind;
      done = 0;
      first = 1'b1;
      while (done < count) begin
         broken = 1'b0;
         if (loud && first) begin
            kind = WAVE_SQUARE;
            period = TAPS;
            amp = 32767;
            len = 450;
         end else begin
            period = $urandom_range(2, 200);
            amp = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(1, 32767);
            if ($urandom_range(0, 9) < 2) begin
               broken = 1'b1;
               kind = WAVE_NOISE;
               len = $urandom_range(1, 70);
            end else begin
               kind = wave_kind_type'($urandom_range(0, 4));
               len = $urandom_range(70, 260);
            end
         end
         lead_flag = (first && loud) || ($urandom_range(0, 7) != 0);
         for (int n = 0; n < len && done < count; n++) begin
            clip = (n == 0) ? lead_flag : (broken && $urandom_range(0, 15) == 0);
            send_sample(wave_value(kind, n, period, amp), clip);
            done++;
         end
         first = 1'b0;
      end
   endtask

   initial begin
      int mode_left, stall_pct;
      mode_left = 0;
      stall_pct = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.envelope, rsp_ch.hilbert_value, rsp_ch.saturated);
         if (mode_left == 0) begin
            mode_left = $urandom_range(20, 300);
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 80);
         end
         mode_left--;
         rsp_ch.ready <= !hold_rsp && ($urandom_range(0, 99) >= stall_pct);
      end
   end

   initial begin
      wait (sent_count >= HOLD_AFTER);
      @(posedge clock);
      hold_rsp = 1'b1;
      repeat (HOLD_CYC) @(posedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      sb = new();
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.sample     <= '0;
      req_ch.clip_start <= 1'b0;
      csr_ch.valid      <= 1'b0;
      csr_ch.decay      <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_samples[i])
         send_sample(directed_samples[i], directed_clip[i]);

      drain_results();
      write_decay('0);
      run_phase(320, 1'b0);

      drain_results();
      write_decay(15'h7FFF);
      run_phase(450, 1'b1);

      drain_results();
      write_decay(DECAY_W'($urandom_range(1, 32766)));
      run_phase(200, 1'b0);

      drain_results();
      write_decay(15'd1);
      run_phase(160, 1'b0);

      drain_results();
      write_decay(DECAY_RESET);
      run_phase(160, 1'b0);

      drain_results();
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
